FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the Modbus register slave.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that cons holds in the same cycle as ante.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/mbrs_pkg.sv
// Package with constants and types of the Modbus RTU register slave.
`timescale 1ns / 1ps
`default_nettype none
package mbrs_pkg;

   localparam int REG_COUNT_DEF = 16;

   localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
   localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'hA001;
   localparam logic [7:0]  ADDR_RESET      = 8'h01;
   localparam int          FRAME_LEN       = 8;
   localparam int          CHECK_LEN       = 6;
   localparam int          READ_HDR_LEN    = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHK_LOAD,
      ST_SHIFT,
      ST_CHK_EVAL,
      ST_RSP_LOAD,
      ST_CRC_LO,
      ST_CRC_HI
   } state_type;

endpackage
`default_nettype wire

FILE: rtl/modbus_rtu_register_slave.sv
// Modbus RTU slave: frame collection, CRC-16 check, register read and write.
//
// Request bytes come in on the req_ stream one beat at a time; eight beats
// make a frame. Bytes one to seven are taken at one beat per cycle. The
// eighth beat starts the frame check: one shared bit-serial CRC-16 unit
// folds the six body bytes at one bit per cycle, then the ST_CHK_EVAL
// state decodes address, CRC and function. Answered frames come out on
// the rsp_ stream, one byte per beat, CRC high byte marked by rsp_tlast.
// Each body byte of the reply passes through the same CRC unit, so the
// next reply byte is not loaded until the unit has folded the last one;
// the two CRC bytes leave one per cycle while the rsp_ side does not
// stall. A read reply holds 5 + 2 * quantity beats, a write echo 8.
// req_tready stays low from the eighth beat until the last reply byte sits
// in the output register; frames that are dropped free the input once
// ST_CHK_EVAL has decoded them. A stalled rsp_ side holds the sequencer at
// its next load; the final byte waits in the output register while new
// request bytes are taken. The csr_ port writes the station address at any
// time the block is idle. Reset clears the frame counter, the holding
// registers and sets the station address to 1.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module modbus_rtu_register_slave #(
   parameter int REG_COUNT = mbrs_pkg::REG_COUNT_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] tx_byte
   output logic            rsp_tlast,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_data     // [7:0] slave_address
);
   import mbrs_pkg::*;

   localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int LEN_W = $clog2(READ_HDR_LEN + 2 * REG_COUNT + 1);

   state_type          state_ff, state_in;
   logic [7:0]         rq_ff [FRAME_LEN];
   logic [2:0]         cnt_ff, cnt_in;
   logic [15:0]        hold_ff [REG_COUNT];
   logic [7:0]         addr_ff;
   logic [15:0]        crc_ff, crc_in;
   logic [2:0]         bit_ff, bit_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               rsp_phase_ff, rsp_phase_in;
   logic               read_mode_ff, read_mode_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic               half_ff, half_in;
   logic               ovalid_ff, ovalid_in;
   logic [7:0]         odata_ff, odata_in;
   logic               olast_ff, olast_in;
   logic               hold_we;

   logic               req_beat;
   logic               out_free;
   logic [15:0]        crc_shift;
   logic [15:0]        reg_a;
   logic [15:0]        reg_v;
   logic [16:0]        read_end;
   logic               frame_ok;
   logic               read_ok;
   logic [7:0]         rsp_byte;
   logic [15:0]        rd_word;
   logic [LEN_W-1:0]   idx_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;
   assign out_free   = !ovalid_ff || rsp_tready;

   // One bit step of the reflected CRC-16
   assign crc_shift = crc_ff[0] ? ({1'b0, crc_ff[15:1]} ^ CRC_POLY) : {1'b0, crc_ff[15:1]};

   // Frame fields
   assign reg_a    = {rq_ff[2], rq_ff[3]};
   assign reg_v    = {rq_ff[4], rq_ff[5]};
   assign read_end = {1'b0, reg_a} + {1'b0, reg_v};
   assign frame_ok = (rq_ff[0] == addr_ff) && (crc_ff == {rq_ff[7], rq_ff[6]});
   assign read_ok  = (reg_v != 16'd0) && (read_end <= 17'(REG_COUNT));
   assign idx_next = idx_ff + LEN_W'(1);
   assign rd_word  = hold_ff[ptr_ff];

   // Pick the next reply body byte
   always_comb begin
      if (read_mode_ff) begin
         if (idx_ff == LEN_W'(0)) begin
            rsp_byte = addr_ff;
         end else if (idx_ff == LEN_W'(1)) begin
            rsp_byte = FN_READ_HOLDING;
         end else if (idx_ff == LEN_W'(2)) begin
            rsp_byte = {reg_v[6:0], 1'b0};
         end else begin
            rsp_byte = half_ff ? rd_word[7:0] : rd_word[15:8];
         end
      end else begin
         rsp_byte = rq_ff[idx_ff[2:0]];
      end
   end

   // Sequencer: next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      crc_in       = crc_ff;
      bit_in       = bit_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      rsp_phase_in = rsp_phase_ff;
      read_mode_in = read_mode_ff;
      ptr_in       = ptr_ff;
      half_in      = half_ff;
      ovalid_in    = ovalid_ff && !rsp_tready;
      odata_in     = odata_ff;
      olast_in     = olast_ff;
      hold_we      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'(FRAME_LEN - 1)) begin
                  crc_in       = CRC_INIT;
                  idx_in       = '0;
                  rsp_phase_in = 1'b0;
                  state_in     = ST_CHK_LOAD;
               end
            end
         end
         ST_CHK_LOAD: begin
            crc_in   = crc_ff ^ {8'h00, rq_ff[idx_ff[2:0]]};
            bit_in   = '0;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            crc_in = crc_shift;
            bit_in = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               idx_in = idx_next;
               if (rsp_phase_ff) begin
                  state_in = (idx_next == len_ff) ? ST_CRC_LO : ST_RSP_LOAD;
               end else begin
                  state_in = (idx_next == LEN_W'(CHECK_LEN)) ? ST_CHK_EVAL : ST_CHK_LOAD;
               end
            end
         end
         ST_CHK_EVAL: begin
            crc_in   = CRC_INIT;
            idx_in   = '0;
            half_in  = 1'b0;
            ptr_in   = reg_a[IDX_W-1:0];
            state_in = ST_IDLE;
            if (frame_ok && rq_ff[1] == FN_READ_HOLDING && read_ok) begin
               read_mode_in = 1'b1;
               len_in       = LEN_W'(17'(READ_HDR_LEN) + {reg_v, 1'b0});
               state_in     = ST_RSP_LOAD;
            end else if (frame_ok && rq_ff[1] == FN_WRITE_SINGLE) begin
               read_mode_in = 1'b0;
               len_in       = LEN_W'(CHECK_LEN);
               hold_we      = (reg_a < 16'(REG_COUNT));
               state_in     = ST_RSP_LOAD;
            end
         end
         ST_RSP_LOAD: begin
            if (out_free) begin
               ovalid_in    = 1'b1;
               odata_in     = rsp_byte;
               olast_in     = 1'b0;
               crc_in       = crc_ff ^ {8'h00, rsp_byte};
               bit_in       = '0;
               rsp_phase_in = 1'b1;
               if (read_mode_ff && idx_ff >= LEN_W'(READ_HDR_LEN)) begin
                  half_in = !half_ff;
                  if (half_ff) begin
                     ptr_in = ptr_ff + IDX_W'(1);
                  end
               end
               state_in = ST_SHIFT;
            end
         end
         ST_CRC_LO: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               odata_in  = crc_ff[7:0];
               olast_in  = 1'b0;
               state_in  = ST_CRC_HI;
            end
         end
         ST_CRC_HI: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               odata_in  = crc_ff[15:8];
               olast_in  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         ovalid_ff <= 1'b0;
         addr_ff   <= ADDR_RESET;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         ovalid_ff <= ovalid_in;
         if (csr_valid && csr_ready) begin
            addr_ff <= csr_data;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      crc_ff       <= crc_in;
      bit_ff       <= bit_in;
      idx_ff       <= idx_in;
      len_ff       <= len_in;
      rsp_phase_ff <= rsp_phase_in;
      read_mode_ff <= read_mode_in;
      ptr_ff       <= ptr_in;
      half_ff      <= half_in;
      odata_ff     <= odata_in;
      olast_ff     <= olast_in;
   end

   // Capture request bytes
   always_ff @(posedge clock) begin
      if (req_beat) begin
         rq_ff[cnt_ff] <= req_tdata;
      end
   end

   // Holding register store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            hold_ff[i] <= '0;
         end
      end else if (hold_we) begin
         hold_ff[reg_a[IDX_W-1:0]] <= reg_v;
      end
   end

   `ASSERT_IMP(a_cnt_clear, clock, reset, state_ff == ST_CHK_LOAD, cnt_ff == 3'd0)
   `ASSERT_IMP(a_body_bound, clock, reset, state_ff == ST_RSP_LOAD, idx_ff < len_ff)
   `ASSERT_IMP(a_ptr_range, clock, reset,
      state_ff == ST_RSP_LOAD && read_mode_ff && idx_ff >= LEN_W'(READ_HDR_LEN),
      int'(ptr_ff) < REG_COUNT)
   `ASSERT_NEXT(a_req_next, clock, reset, req_beat,
      state_ff == ST_IDLE || state_ff == ST_CHK_LOAD)

endmodule
`default_nettype wire

FILE: tb/modbus_reply_checker.sv
// Reply predictor and scoreboard for the Modbus RTU register slave.
`timescale 1ns / 1ps
module modbus_reply_checker #(
   parameter int REG_COUNT = mbrs_pkg::REG_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tlast,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [7:0] csr_data,
   output int         mismatch_total,
   output int         replies_due
);
   import mbrs_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } reply_beat_type;

   reply_beat_type reply_q[$];
   logic [7:0]  frame_buf [FRAME_LEN];
   int          frame_fill;
   logic [15:0] holding [REG_COUNT];
   logic [7:0]  station;
   int          fails;
   int          beat_index;

   // Fold one byte into the running CRC-16, LSB first.
   function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   task automatic push_body(input logic [7:0] b, inout logic [15:0] crc);
      reply_q.push_back('{data: b, last: 1'b0});
      crc = crc16_fold(crc, b);
   endtask

   // Close the reply: CRC low byte, then CRC high byte marked last.
   task automatic push_crc(input logic [15:0] crc);
      reply_q.push_back('{data: crc[7:0], last: 1'b0});
      reply_q.push_back('{data: crc[15:8], last: 1'b1});
   endtask

   // Decode a complete request frame and queue the reply it earns.
   task automatic answer_frame();
      logic [15:0] crc;
      logic [15:0] first_reg;
      logic [15:0] word;
      logic [16:0] span;
      if (frame_buf[0] != station)
         return;
      crc = CRC_INIT;
      for (int i = 0; i < CHECK_LEN; i++)
         crc = crc16_fold(crc, frame_buf[i]);
      if (crc != {frame_buf[7], frame_buf[6]})
         return;
      first_reg = {frame_buf[2], frame_buf[3]};
      word      = {frame_buf[4], frame_buf[5]};
      span      = {1'b0, first_reg} + {1'b0, word};
      crc       = CRC_INIT;
      case (frame_buf[1])
         FN_READ_HOLDING: begin
            if (word == 16'd0 || span > REG_COUNT)
               return;
            push_body(station, crc);
            push_body(FN_READ_HOLDING, crc);
            push_body({word[6:0], 1'b0}, crc);
            for (int r = int'(first_reg); r < int'(span); r++) begin
               push_body(holding[r][15:8], crc);
               push_body(holding[r][7:0], crc);
            end
            push_crc(crc);
         end
         FN_WRITE_SINGLE: begin
            // Out-of-range writes leave the store alone but still echo.
            if (first_reg < REG_COUNT)
               holding[first_reg] = word;
            for (int i = 0; i < CHECK_LEN; i++)
               push_body(frame_buf[i], crc);
            push_crc(crc);
         end
         default: ;
      endcase
   endtask

   task automatic note_failure(input string what, input int want, input int got);
      fails++;
      if (fails <= REPORT_LIMIT)
         $display("%0t: reply beat %0d: %s expected %02h, got %02h",
                  $realtime, beat_index, what, want, got);
   endtask

   // Track configuration, collect request beats and check reply beats.
   always @(posedge clock) begin
      reply_beat_type want;
      if (reset) begin
         reply_q.delete();
         frame_fill = 0;
         station    = ADDR_RESET;
         foreach (holding[i])
            holding[i] = '0;
      end else begin
         if (csr_valid && csr_ready)
            station = csr_data;
         if (req_tvalid && req_tready) begin
            frame_buf[frame_fill] = req_tdata;
            frame_fill++;
            if (frame_fill == FRAME_LEN) begin
               frame_fill = 0;
               answer_frame();
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (reply_q.size() == 0) begin
               fails++;
               if (fails <= REPORT_LIMIT)
                  $display("%0t: reply beat %0d: unexpected, tx_byte %02h last %0d",
                           $realtime, beat_index, rsp_tdata, rsp_tlast);
            end else begin
               want = reply_q.pop_front();
               if (rsp_tdata !== want.data)
                  note_failure("tx_byte", want.data, rsp_tdata);
               if (rsp_tlast !== want.last)
                  note_failure("last_byte", want.last, rsp_tlast);
            end
            beat_index++;
         end
      end
      replies_due    <= reply_q.size();
      mismatch_total <= fails;
   end

endmodule

FILE: tb/modbus_rtu_register_slave_test.sv
// Top-level testbench of the Modbus RTU register slave: stimulus and verdict.
`timescale 1ns / 1ps
module modbus_rtu_register_slave_test;
   import mbrs_pkg::*;

   localparam int REGS = REG_COUNT_DEF;

   typedef enum {
      FR_READ,
      FR_WRITE,
      FR_WRITE_OUT,
      FR_READ_EMPTY,
      FR_READ_OVER,
      FR_FOREIGN,
      FR_BAD_CRC,
      FR_BAD_FUNC,
      FR_NOISE
   } frame_kind_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic [7:0] req_tdata  = 8'h00;
   logic       rsp_tready = 1'b0;
   logic       csr_valid  = 1'b0;
   logic [7:0] csr_data   = 8'h00;
   logic       req_tready;
   logic       rsp_tvalid;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_ready;
   int         mismatches;
   int         replies_due;

   bit         calm         = 1'b0;
   bit         hold_off_req = 1'b0;
   logic [7:0] station      = ADDR_RESET;

   modbus_rtu_register_slave dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   modbus_reply_checker #(.REG_COUNT(REGS)) scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_total (mismatches),
      .replies_due    (replies_due)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Guard against a hung handshake.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Drive the reply side: random ready bursts, one long hold-off on request.
   initial begin
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_tready   <= 1'b0;
            hold_off_req = 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
            if (!calm) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(1, 9)) @(posedge clock);
            end
         end
      end
   end

   // CRC-16 of a request body, used to seal outgoing frames.
   function automatic logic [15:0] seal_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   // Offer one request beat, with an occasional random gap before it.
   task automatic send_byte(input logic [7:0] b);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // Send a full frame; a nonzero crc_flip corrupts the CRC.
   task automatic send_frame(input logic [7:0] addr, input logic [7:0] fn,
                             input logic [15:0] w1, input logic [15:0] w2,
                             input logic [15:0] crc_flip);
      logic [7:0]  body [6];
      logic [15:0] crc;
      body = '{addr, fn, w1[15:8], w1[7:0], w2[15:8], w2[7:0]};
      crc  = CRC_INIT;
      foreach (body[i]) begin
         send_byte(body[i]);
         crc = seal_fold(crc, body[i]);
      end
      crc ^= crc_flip;
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
   endtask

   // Hold the sender until every reply is back, then let a dropped frame finish.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (replies_due != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_station(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      station = value;
   endtask

   // Pick a frame kind, mostly well formed, and send it.
   task automatic random_frame();
      frame_kind_type kind;
      int          pick;
      int          room;
      logic [15:0] start;
      logic [15:0] qty;
      logic [7:0]  fn;
      pick = $urandom_range(0, 99);
      if (pick < 30)      kind = FR_READ;
      else if (pick < 55) kind = FR_WRITE;
      else if (pick < 61) kind = FR_WRITE_OUT;
      else if (pick < 66) kind = FR_READ_EMPTY;
      else if (pick < 73) kind = FR_READ_OVER;
      else if (pick < 79) kind = FR_FOREIGN;
      else if (pick < 86) kind = FR_BAD_CRC;
      else if (pick < 93) kind = FR_BAD_FUNC;
      else                kind = FR_NOISE;

      // Valid read window, mostly short, sometimes to the top of the store.
      start = 16'($urandom_range(0, REGS - 1));
      room  = REGS - int'(start);
      if ($urandom_range(0, 3) == 0)
         qty = 16'(room);
      else
         qty = 16'($urandom_range(1, room < 3 ? room : 3));
      fn = $urandom_range(0, 1) ? FN_READ_HOLDING : FN_WRITE_SINGLE;

      case (kind)
         FR_READ:
            send_frame(station, FN_READ_HOLDING, start, qty, 16'h0000);
         FR_WRITE:
            send_frame(station, FN_WRITE_SINGLE, start,
                       $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom), 16'h0000);
         FR_WRITE_OUT:
            send_frame(station, FN_WRITE_SINGLE,
                       $urandom_range(0, 2) == 0 ? 16'hFFFF : 16'($urandom_range(REGS, 65535)),
                       16'($urandom), 16'h0000);
         FR_READ_EMPTY:
            send_frame(station, FN_READ_HOLDING, start, 16'h0000, 16'h0000);
         FR_READ_OVER: begin
            if ($urandom_range(0, 1)) begin
               start = 16'($urandom_range(0, REGS));
               qty   = 16'(REGS - int'(start) + $urandom_range(1, 4));
            end else begin
               start = 16'($urandom_range(REGS, 65535));
               qty   = 16'($urandom_range(1, 65535));
            end
            send_frame(station, FN_READ_HOLDING, start, qty, 16'h0000);
         end
         FR_FOREIGN:
            send_frame(station ^ 8'($urandom_range(1, 255)), fn, start, qty, 16'h0000);
         FR_BAD_CRC:
            send_frame(station, fn, start, qty, 16'($urandom_range(1, 65535)));
         FR_BAD_FUNC: begin
            do
               fn = 8'($urandom_range(0, 255));
            while (fn == FN_READ_HOLDING || fn == FN_WRITE_SINGLE);
            send_frame(station, fn, 16'($urandom), 16'($urandom), 16'h0000);
         end
         default:
            repeat (FRAME_LEN) send_byte(8'($urandom_range(0, 255)));
      endcase
   endtask

   // Main sequence: reset, directed frames, then address phases of random frames.
   initial begin
      logic [7:0] next_station;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Fill the top register with all ones, read the whole store, send a bad CRC.
      send_frame(station, FN_WRITE_SINGLE, 16'(REGS - 1), 16'hFFFF, 16'h0000);
      send_frame(station, FN_READ_HOLDING, 16'h0000, 16'(REGS), 16'h0000);
      send_frame(station, FN_READ_HOLDING, 16'h0000, 16'h0001, 16'h0001);
      settle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       next_station = 8'd0;
            1:       next_station = 8'd255;
            2:       next_station = 8'd247;
            5:       next_station = 8'd1;
            default: next_station = 8'($urandom_range(2, 246));
         endcase
         write_station(next_station);
         if (phase == 5)
            calm = 1'b1;
         // Stall the reply side behind a full-store read so the input backs up.
         if (phase == 2) begin
            hold_off_req = 1'b1;
            send_frame(station, FN_READ_HOLDING, 16'h0000, 16'(REGS), 16'h0000);
         end
         repeat (2) random_frame();
         settle();
      end

      if (mismatches == 0 && replies_due == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
